@@ src/whpf_pkg.sv @@
// shared types and constants for the wildcard header packet filter
package whpf_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DST_MAC   = 3'd0,
		REG_SRC_MAC   = 3'd1,
		REG_ETHERTYPE = 3'd2,
		REG_DST_IP    = 3'd3,
		REG_SRC_IP    = 3'd4,
		REG_PROTOCOL  = 3'd5,
		REG_DST_PORT  = 3'd6,
		REG_SRC_PORT  = 3'd7
	} reg_index_t;

	localparam int CFG_DATA_W = 48;

	// header field values
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// byte offsets in the frame
	localparam logic [15:0] OFS_SRC_MAC   = 16'd6;
	localparam logic [15:0] OFS_ETYPE     = 16'd12;
	localparam logic [15:0] OFS_ETYPE_END = 16'd14;
	localparam logic [15:0] OFS_PROTOCOL  = 16'd23;
	localparam logic [15:0] OFS_SRC_IP    = 16'd26;
	localparam logic [15:0] OFS_DST_IP    = 16'd30;
	localparam logic [15:0] OFS_SRC_PORT  = 16'd34;
	localparam logic [15:0] OFS_DST_PORT  = 16'd36;
	localparam logic [15:0] OFS_PORT_END  = 16'd38;

	// minimum frame lengths for each header
	localparam logic [15:0] MIN_LEN_ETH = 16'd14;
	localparam logic [15:0] MIN_LEN_IP  = 16'd34;
	localparam logic [15:0] MIN_LEN_UDP = 16'd42;
	localparam logic [15:0] MIN_LEN_TCP = 16'd54;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

endpackage

@@ src/wildcard_header_packet_filter.sv @@
// wildcard header packet filter: byte-wise header parse and capture verdict
//
// Frame bytes come in on the input channel, one word per byte, in wire order,
// with last_byte set on the final byte. Each byte lands in an input register
// and is then compared against the match registers, updating the position
// counter and the per-field match flags. On the final byte the capture
// verdict and the saturating frame length are loaded into the result
// register and shown on the output channel; other bytes give no result word.
// Throughput is one byte per cycle while in_stall is low. The final byte
// passes through the input register, then the result register, and its
// result word is valid once it is in the result register.
// If the receiver stalls, a final byte waiting behind a full result register
// holds the input register and stall is raised on the input; bytes that are
// not final always move on. Configuration writes are registered; the user
// must make them between frames; the block does not enforce this. Reset
// (arst_n low) clears all match registers to zero, empties both registers
// and starts a new frame.
module wildcard_header_packet_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [whpf_pkg::CFG_DATA_W-1:0] cfg_data,
	// byte input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      packet_byte,
	input  logic                            last_byte,
	// verdict output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            capture,
	output logic [15:0]                     frame_length
);
	import whpf_pkg::*;

	// match registers
	logic [47:0] dst_mac_q, src_mac_q;
	logic [15:0] ethertype_q, dst_port_q, src_port_q;
	logic [31:0] dst_ip_q, src_ip_q;
	logic [7:0]  protocol_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// per-frame state
	logic [15:0] pos_q;
	logic        dst_mac_ok_q, src_mac_ok_q, dst_ip_ok_q, src_ip_ok_q;
	logic        dst_port_ok_q, src_port_ok_q;
	logic [15:0] etype_q;
	logic [7:0]  seen_proto_q;

	// result register
	logic        out_valid_q;
	logic        capture_q;
	logic [15:0] length_q;

	logic        in_accept, s1_go;
	logic [15:0] pos_next;
	logic        dst_mac_ok_d, src_mac_ok_d, dst_ip_ok_d, src_ip_ok_d;
	logic        dst_port_ok_d, src_port_ok_d;
	logic [15:0] etype_d;
	logic [7:0]  seen_proto_d;
	logic        verdict;

	logic [7:0]  dmac_b [6];
	logic [7:0]  smac_b [6];
	logic [7:0]  dip_b [4];
	logic [7:0]  sip_b [4];
	logic [7:0]  dport_b [2];
	logic [7:0]  sport_b [2];
	logic [15:0] ofs_smac, ofs_sip, ofs_dip, ofs_sport, ofs_dport;

	// handshake
	assign s1_go     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_go;
	assign in_accept = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_mac_q   <= '0;
			src_mac_q   <= '0;
			ethertype_q <= '0;
			dst_ip_q    <= '0;
			src_ip_q    <= '0;
			protocol_q  <= '0;
			dst_port_q  <= '0;
			src_port_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_DST_MAC:   dst_mac_q   <= cfg_data;
				REG_SRC_MAC:   src_mac_q   <= cfg_data;
				REG_ETHERTYPE: ethertype_q <= cfg_data[15:0];
				REG_DST_IP:    dst_ip_q    <= cfg_data[31:0];
				REG_SRC_IP:    src_ip_q    <= cfg_data[31:0];
				REG_PROTOCOL:  protocol_q  <= cfg_data[7:0];
				REG_DST_PORT:  dst_port_q  <= cfg_data[15:0];
				REG_SRC_PORT:  src_port_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
		end
	end

	// match register bytes, first wire byte first
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			dmac_b[i] = dst_mac_q[8*(5-i) +: 8];
			smac_b[i] = src_mac_q[8*(5-i) +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			dip_b[i] = dst_ip_q[8*(3-i) +: 8];
			sip_b[i] = src_ip_q[8*(3-i) +: 8];
		end
		for (int i = 0; i < 2; i++) begin
			dport_b[i] = dst_port_q[8*(1-i) +: 8];
			sport_b[i] = src_port_q[8*(1-i) +: 8];
		end
	end

	assign ofs_smac  = pos_q - OFS_SRC_MAC;
	assign ofs_sip   = pos_q - OFS_SRC_IP;
	assign ofs_dip   = pos_q - OFS_DST_IP;
	assign ofs_sport = pos_q - OFS_SRC_PORT;
	assign ofs_dport = pos_q - OFS_DST_PORT;

	// byte compare and field capture at the current position
	always_comb begin
		dst_mac_ok_d  = dst_mac_ok_q;
		src_mac_ok_d  = src_mac_ok_q;
		dst_ip_ok_d   = dst_ip_ok_q;
		src_ip_ok_d   = src_ip_ok_q;
		dst_port_ok_d = dst_port_ok_q;
		src_port_ok_d = src_port_ok_q;
		etype_d       = etype_q;
		seen_proto_d  = seen_proto_q;
		priority if (pos_q < OFS_SRC_MAC) begin
			if (byte_s1 != dmac_b[pos_q[2:0]]) dst_mac_ok_d = 1'b0;
		end else if (pos_q < OFS_ETYPE) begin
			if (byte_s1 != smac_b[ofs_smac[2:0]]) src_mac_ok_d = 1'b0;
		end else if (pos_q < OFS_ETYPE_END) begin
			etype_d = {etype_q[7:0], byte_s1};
		end else if (pos_q == OFS_PROTOCOL) begin
			seen_proto_d = byte_s1;
		end else if (pos_q >= OFS_SRC_IP && pos_q < OFS_DST_IP) begin
			if (byte_s1 != sip_b[ofs_sip[1:0]]) src_ip_ok_d = 1'b0;
		end else if (pos_q >= OFS_DST_IP && pos_q < OFS_SRC_PORT) begin
			if (byte_s1 != dip_b[ofs_dip[1:0]]) dst_ip_ok_d = 1'b0;
		end else if (pos_q >= OFS_SRC_PORT && pos_q < OFS_DST_PORT) begin
			if (byte_s1 != sport_b[ofs_sport[0]]) src_port_ok_d = 1'b0;
		end else if (pos_q >= OFS_DST_PORT && pos_q < OFS_PORT_END) begin
			if (byte_s1 != dport_b[ofs_dport[0]]) dst_port_ok_d = 1'b0;
		end else begin
			// bytes outside the parsed fields leave the state alone
		end
	end

	assign pos_next = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;

	// capture verdict from the updated frame state
	always_comb begin
		verdict = 1'b1;
		priority if (pos_next < MIN_LEN_ETH) begin
			verdict = 1'b0;
		end else if (dst_mac_q != '0 && !dst_mac_ok_d) begin
			verdict = 1'b0;
		end else if (src_mac_q != '0 && !src_mac_ok_d) begin
			verdict = 1'b0;
		end else if (ethertype_q != '0 && etype_d != ethertype_q) begin
			verdict = 1'b0;
		end else if (ethertype_q == '0) begin
			verdict = 1'b1;
		end else if (etype_d != ETHERTYPE_IPV4) begin
			verdict = 1'b1;
		end else if (pos_next < MIN_LEN_IP) begin
			verdict = 1'b0;
		end else if (dst_ip_q != '0 && !dst_ip_ok_d) begin
			verdict = 1'b0;
		end else if (src_ip_q != '0 && !src_ip_ok_d) begin
			verdict = 1'b0;
		end else if (seen_proto_d != protocol_q) begin
			verdict = 1'b0;
		end else if (seen_proto_d == PROTO_UDP || seen_proto_d == PROTO_TCP) begin
			priority if (seen_proto_d == PROTO_UDP && pos_next < MIN_LEN_UDP) begin
				verdict = 1'b0;
			end else if (seen_proto_d == PROTO_TCP && pos_next < MIN_LEN_TCP) begin
				verdict = 1'b0;
			end else if (dst_port_q != '0 && !dst_port_ok_d) begin
				verdict = 1'b0;
			end else if (src_port_q != '0 && !src_port_ok_d) begin
				verdict = 1'b0;
			end else begin
				verdict = 1'b1;
			end
		end else begin
			verdict = 1'b1;
		end
	end

	// per-frame state, back to start after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			dst_mac_ok_q  <= 1'b1;
			src_mac_ok_q  <= 1'b1;
			dst_ip_ok_q   <= 1'b1;
			src_ip_ok_q   <= 1'b1;
			dst_port_ok_q <= 1'b1;
			src_port_ok_q <= 1'b1;
			etype_q       <= '0;
			seen_proto_q  <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				pos_q         <= '0;
				dst_mac_ok_q  <= 1'b1;
				src_mac_ok_q  <= 1'b1;
				dst_ip_ok_q   <= 1'b1;
				src_ip_ok_q   <= 1'b1;
				dst_port_ok_q <= 1'b1;
				src_port_ok_q <= 1'b1;
				etype_q       <= '0;
				seen_proto_q  <= '0;
			end else begin
				pos_q         <= pos_next;
				dst_mac_ok_q  <= dst_mac_ok_d;
				src_mac_ok_q  <= src_mac_ok_d;
				dst_ip_ok_q   <= dst_ip_ok_d;
				src_ip_ok_q   <= src_ip_ok_d;
				dst_port_ok_q <= dst_port_ok_d;
				src_port_ok_q <= src_port_ok_d;
				etype_q       <= etype_d;
				seen_proto_q  <= seen_proto_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			capture_q <= verdict;
			length_q  <= pos_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign capture      = capture_q;
	assign frame_length = length_q;

endmodule
